[rtl/cia_pkg.sv]
`default_nettype none
package cia_pkg;

    localparam int Width   = 64;
    localparam int OpWidth = 5;
    // one quotient bit per stage; the sign fix-up stage is not counted here
    localparam int DivStages = Width;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_SDIV = 5'd3,
        OP_SREM = 5'd4,
        OP_UDIV = 5'd5,
        OP_UREM = 5'd6,
        OP_AND  = 5'd7,
        OP_OR   = 5'd8,
        OP_XOR  = 5'd9,
        OP_SHL  = 5'd10,
        OP_LSHR = 5'd11,
        OP_ASHR = 5'd12,
        OP_EQ   = 5'd13,
        OP_NE   = 5'd14,
        OP_SLT  = 5'd15,
        OP_SLE  = 5'd16,
        OP_SGT  = 5'd17,
        OP_SGE  = 5'd18,
        OP_ULT  = 5'd19,
        OP_ULE  = 5'd20,
        OP_UGT  = 5'd21,
        OP_UGE  = 5'd22
    } op_t;

    typedef struct packed {
        logic [OpWidth-1:0]      req_type;
        logic signed [Width-1:0] left_operand;
        logic signed [Width-1:0] right_operand;
    } req_t;

    typedef struct packed {
        logic signed [Width-1:0] result_value;
        logic                    trapped;
        logic                    is_boolean;
    } rsp_t;

    // word carried down the chain of cells
    typedef struct packed {
        logic             valid;
        logic             is_div;    // result comes from the divider
        logic             want_rem;
        logic             neg_q;
        logic             neg_r;
        logic [Width-1:0] rem;       // partial remainder
        logic [Width-1:0] quo;       // dividend shifting out, quotient shifting in
        logic [Width-1:0] dvs;       // divisor magnitude
        rsp_t             rsp;       // finished result for non-divide ops
    } cell_word_t;

endpackage
`default_nettype wire

[rtl/cia_div_cell.sv]
`default_nettype none
module cia_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire cia_pkg::cell_word_t word_in,
    output cia_pkg::cell_word_t     word_out
);
    import cia_pkg::*;

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;
    logic [Width:0] trial;
    logic [Width:0] shifted;

    always_comb
    begin
        word_next = word_in;
        shifted   = {word_in.rem, word_in.quo[Width-1]};
        trial     = shifted - {1'b0, word_in.dvs};
        if (word_in.is_div)
        begin
            if (!trial[Width])
            begin
                word_next.rem = trial[Width-1:0];
                word_next.quo = {word_in.quo[Width-2:0], 1'b1};
            end
            else
            begin
                word_next.rem = shifted[Width-1:0];
                word_next.quo = {word_in.quo[Width-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= word_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            word_reg <= word_next;
    end

    always_comb
    begin
        word_out       = word_reg;
        word_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

[rtl/cia_front.sv]
`default_nettype none
module cia_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               in_fire,
    input  wire cia_pkg::req_t      req,
    output cia_pkg::cell_word_t     word_out
);
    import cia_pkg::*;

    // stage 1: decode, simple ops, partial products
    logic             s1_valid_reg;
    logic             s1_is_mul_reg;
    logic             s1_is_div_reg;
    logic             s1_want_rem_reg;
    logic             s1_neg_q_reg;
    logic             s1_neg_r_reg;
    logic             s1_mul_neg_reg;
    logic             s1_za_reg;
    logic [Width-1:0] s1_ua_reg;
    logic [Width-1:0] s1_ub_reg;
    logic [Width-1:0] s1_p00_reg, s1_p01_reg, s1_p10_reg, s1_p11_reg;
    rsp_t             s1_rsp_reg;

    logic [Width-1:0] a, b, ua, ub, sum, dif;
    logic [Width-1:0] shl, lshr, ashr;
    logic [5:0]       sh;
    logic             sh_bad, a_min, b_m1, b_zero;
    rsp_t             rsp;
    logic             is_mul, is_div, want_rem, neg_q, neg_r;
    logic [Width-1:0] dua, dub;
    op_t              op;

    always_comb
    begin
        a      = req.left_operand;
        b      = req.right_operand;
        op     = op_t'(req.req_type);
        ua     = a[Width-1] ? (Width'(0) - a) : a;
        ub     = b[Width-1] ? (Width'(0) - b) : b;
        sum    = a + b;
        dif    = a - b;
        sh     = b[5:0];
        sh_bad = (b[Width-1:6] != '0);
        shl    = a << sh;
        lshr   = a >> sh;
        ashr   = Width'($signed(a) >>> sh);
        a_min  = (a == {1'b1, {(Width-1){1'b0}}});
        b_m1   = (b == {Width{1'b1}});
        b_zero = (b == '0);
        rsp    = '0;
        is_mul = 1'b0;
        is_div = 1'b0;
        want_rem = 1'b0;
        neg_q  = 1'b0;
        neg_r  = 1'b0;
        dua    = a;
        dub    = b;
        unique case (req.req_type)
            OP_ADD:
                if (((a ^ sum) & (b ^ sum)) >> (Width-1) != '0) rsp.trapped = 1'b1;
                else rsp.result_value = sum;
            OP_SUB:
                if (((a ^ b) & (a ^ dif)) >> (Width-1) != '0) rsp.trapped = 1'b1;
                else rsp.result_value = dif;
            OP_MUL: is_mul = 1'b1;
            OP_SDIV, OP_SREM:
                if (b_zero || (a_min && b_m1)) rsp.trapped = 1'b1;
                else
                begin
                    is_div   = 1'b1;
                    want_rem = (op == OP_SREM);
                    neg_q    = a[Width-1] ^ b[Width-1];
                    neg_r    = a[Width-1];
                    dua      = ua;
                    dub      = ub;
                end
            OP_UDIV, OP_UREM:
                if (b_zero) rsp.trapped = 1'b1;
                else
                begin
                    is_div   = 1'b1;
                    want_rem = (op == OP_UREM);
                end
            OP_AND: rsp.result_value = a & b;
            OP_OR:  rsp.result_value = a | b;
            OP_XOR: rsp.result_value = a ^ b;
            OP_SHL, OP_LSHR, OP_ASHR:
                if (sh_bad) rsp.trapped = 1'b1;
                else if (op == OP_SHL) rsp.result_value = shl;
                else if (op == OP_LSHR) rsp.result_value = lshr;
                else rsp.result_value = ashr;
            OP_EQ:  begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a == b); end
            OP_NE:  begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a != b); end
            OP_SLT: begin rsp.is_boolean = 1'b1;
                rsp.result_value = Width'($signed(a) < $signed(b)); end
            OP_SLE: begin rsp.is_boolean = 1'b1;
                rsp.result_value = Width'($signed(a) <= $signed(b)); end
            OP_SGT: begin rsp.is_boolean = 1'b1;
                rsp.result_value = Width'($signed(a) > $signed(b)); end
            OP_SGE: begin rsp.is_boolean = 1'b1;
                rsp.result_value = Width'($signed(a) >= $signed(b)); end
            OP_ULT: begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a < b); end
            OP_ULE: begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a <= b); end
            OP_UGT: begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a > b); end
            OP_UGE: begin rsp.is_boolean = 1'b1; rsp.result_value = Width'(a >= b); end
            default: rsp = '0;
        endcase
        if (!is_mul)
        begin
            dua = is_div ? dua : '0;
        end
        else
        begin
            dua = ua;
            dub = ub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_is_mul_reg   <= is_mul;
            s1_is_div_reg   <= is_div;
            s1_want_rem_reg <= want_rem;
            s1_neg_q_reg    <= neg_q;
            s1_neg_r_reg    <= neg_r;
            s1_mul_neg_reg  <= a[Width-1] ^ b[Width-1];
            s1_za_reg       <= (ua == '0) || (ub == '0);
            s1_ua_reg       <= dua;
            s1_ub_reg       <= dub;
            s1_p00_reg      <= ua[31:0]  * ub[31:0];
            s1_p01_reg      <= ua[31:0]  * ub[63:32];
            s1_p10_reg      <= ua[63:32] * ub[31:0];
            s1_p11_reg      <= ua[63:32] * ub[63:32];
            s1_rsp_reg      <= rsp;
        end
    end

    // stage 2: combine partial products, overflow check
    logic [Width-1:0] mid, lo, hi;
    logic             neg, ovf;
    cell_word_t       w;
    logic             s2_valid_reg;
    cell_word_t       s2_word_reg;

    always_comb
    begin
        mid = (s1_p00_reg >> 32) + {32'b0, s1_p01_reg[31:0]} + {32'b0, s1_p10_reg[31:0]};
        lo  = {mid[31:0], s1_p00_reg[31:0]};
        hi  = s1_p11_reg + (s1_p01_reg >> 32) + (s1_p10_reg >> 32) + (mid >> 32);
        neg = s1_mul_neg_reg && !s1_za_reg;
        if (hi != '0) ovf = 1'b1;
        else if (neg) ovf = (lo > {1'b1, {(Width-1){1'b0}}});
        else ovf = lo[Width-1];
        w          = '0;
        w.valid    = s1_valid_reg;
        w.is_div   = s1_is_div_reg;
        w.want_rem = s1_want_rem_reg;
        w.neg_q    = s1_neg_q_reg;
        w.neg_r    = s1_neg_r_reg;
        w.quo      = s1_ua_reg;
        w.dvs      = s1_ub_reg;
        w.rsp      = s1_rsp_reg;
        if (s1_is_mul_reg)
        begin
            w.rsp.trapped      = ovf;
            w.rsp.result_value = ovf ? '0 : (neg ? (Width'(0) - lo) : lo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= w.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s2_word_reg <= w;
    end

    always_comb
    begin
        word_out       = s2_word_reg;
        word_out.valid = s2_valid_reg;
    end

endmodule
`default_nettype wire

[rtl/checked_integer_alu_top.sv]
`default_nettype none
// Checked 64-bit integer ALU. Takes one word per cycle while the output is not
// stalled and returns one result word per input, in order.
// Every operation flows through the same pipe: two front stages (decode, simple
// ops, 32x32 partial products and multiply overflow check), a chain of 64
// restoring-divide cells, one quotient bit per cell, and an output register
// with sign fix-up. The whole pipe stalls when the output word is not taken.
module checked_integer_alu_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cia_pkg::req_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cia_pkg::rsp_t       out_data
);
    import cia_pkg::*;

    logic       advance;
    cell_word_t chain [DivStages+1];
    rsp_t       fin;
    logic       out_valid_reg;
    rsp_t       out_data_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    cia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_fire  (in_valid && in_ready),
        .req      (in_data),
        .word_out (chain[0])
    );

    for (genvar i = 0; i < DivStages; i++)
    begin : g_cell
        cia_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    always_comb
    begin
        fin = chain[DivStages].rsp;
        if (chain[DivStages].is_div)
        begin
            fin.trapped    = 1'b0;
            fin.is_boolean = 1'b0;
            if (chain[DivStages].want_rem)
                fin.result_value = chain[DivStages].neg_r
                    ? (Width'(0) - chain[DivStages].rem) : chain[DivStages].rem;
            else
                fin.result_value = chain[DivStages].neg_q
                    ? (Width'(0) - chain[DivStages].quo) : chain[DivStages].quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[DivStages].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= fin;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.trapped |-> out_data.result_value == '0 && !out_data.is_boolean)
        else $error("trapped word carries a value");
    a_bool_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_boolean |-> out_data.result_value[Width-1:1] == '0)
        else $error("compare result not 0 or 1");

endmodule
`default_nettype wire

[tb/sv/tb_checked_integer_alu_top.sv]
`default_nettype none
module tb_checked_integer_alu_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cia_pkg::*;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] AllOnes = '1;
    localparam int NumRandom = 1530;
    localparam int PipeDepth = DivStages + 3;
    localparam int MaxWait = 18;

    class alu_scoreboard;
        rsp_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function rsp_t alu_result(req_t r);
            rsp_t o;
            logic [63:0] a, b, s, ua, ub, q, m;
            logic [127:0] p;
            logic neg;
            a = r.left_operand;
            b = r.right_operand;
            o = '0;
            s = '0;
            case (r.req_type)
                OP_ADD:
                begin
                    s = a + b;
                    o.trapped = (a[63] ^ s[63]) & (b[63] ^ s[63]);
                end
                OP_SUB:
                begin
                    s = a - b;
                    o.trapped = (a[63] ^ b[63]) & (a[63] ^ s[63]);
                end
                OP_MUL:
                begin
                    ua = a[63] ? -a : a;
                    ub = b[63] ? -b : b;
                    p = ua * ub;
                    neg = (a[63] ^ b[63]) && ua != 0 && ub != 0;
                    m = p[63:0];
                    if (p[127:64] != 0 || (neg ? m > MinVal : m >= MinVal))
                        o.trapped = 1'b1;
                    else
                        s = neg ? -m : m;
                end
                OP_SDIV, OP_SREM:
                begin
                    if (b == 0 || (a == MinVal && b == AllOnes))
                        o.trapped = 1'b1;
                    else
                    begin
                        ua = a[63] ? -a : a;
                        ub = b[63] ? -b : b;
                        q = ua / ub;
                        m = ua % ub;
                        if (r.req_type == OP_SDIV)
                            s = (a[63] ^ b[63]) ? -q : q;
                        else
                            s = a[63] ? -m : m;
                    end
                end
                OP_UDIV:
                    if (b == 0) o.trapped = 1'b1; else s = a / b;
                OP_UREM:
                    if (b == 0) o.trapped = 1'b1; else s = a % b;
                OP_AND: s = a & b;
                OP_OR:  s = a | b;
                OP_XOR: s = a ^ b;
                OP_SHL, OP_LSHR, OP_ASHR:
                    if (b > 63)
                        o.trapped = 1'b1;
                    else if (r.req_type == OP_SHL)
                        s = a << b[5:0];
                    else if (r.req_type == OP_LSHR)
                        s = a >> b[5:0];
                    else
                        s = $signed(a) >>> b[5:0];
                OP_EQ:  s = 64'(a == b);
                OP_NE:  s = 64'(a != b);
                OP_SLT: s = 64'($signed(a) < $signed(b));
                OP_SLE: s = 64'($signed(a) <= $signed(b));
                OP_SGT: s = 64'($signed(a) > $signed(b));
                OP_SGE: s = 64'($signed(a) >= $signed(b));
                OP_ULT: s = 64'(a < b);
                OP_ULE: s = 64'(a <= b);
                OP_UGT: s = 64'(a > b);
                OP_UGE: s = 64'(a >= b);
                default: ;
            endcase
            o.is_boolean = r.req_type >= OP_EQ && r.req_type <= OP_UGE;
            o.result_value = o.trapped ? '0 : s;
            return o;
        endfunction

        function void note_request(req_t r);
            pending.push_back(alu_result(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
            begin
                $error("result_value: expected %h, got %h", want.result_value,
                    got.result_value);
                errors++;
            end
            if (got.trapped !== want.trapped)
            begin
                $error("trapped: expected %b, got %b", want.trapped, got.trapped);
                errors++;
            end
            if (got.is_boolean !== want.is_boolean)
            begin
                $error("is_boolean: expected %b, got %b", want.is_boolean,
                    got.is_boolean);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;
    logic sending_done;
    alu_scoreboard board;

    checked_integer_alu_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MinVal;
            1: return MaxVal;
            2: return AllOnes;
            3: return 64'(0);
            4: return 64'($urandom_range(0, 70));
            5: return -64'($urandom_range(1, 70));
            6: return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // wait count drawn per word; sometimes a run of back-to-back words
    function automatic int pick_gap(int burst);
        if (burst != 0) return 0;
        return $urandom_range(0, MaxWait);
    endfunction

    // valid drops only while idling, so back-to-back words keep it high
    task automatic send_word(req_t r, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        board.note_request(r);
    endtask

    task automatic send_directed();
        logic [63:0] ops[10];
        req_t r;
        ops = '{64'(0), 64'(1), AllOnes, MinVal, MaxVal, 64'(63), 64'(64),
            64'h5A5A_A5A5_0F0F_F0F0, -64'(7), 64'(3)};
        // MIN / -1 on signed divides, add/sub overflow, mul at the MIN edge
        send_word('{OP_SDIV, MinVal, AllOnes}, 0);
        send_word('{OP_SREM, MinVal, AllOnes}, 0);
        send_word('{OP_ADD, MaxVal, 64'(1)}, 0);
        send_word('{OP_SUB, MinVal, 64'(1)}, 0);
        send_word('{OP_MUL, MinVal, AllOnes}, 0);
        send_word('{OP_MUL, 64'h1_0000_0000, 64'h8000_0000}, 0);
        send_word('{OP_MUL, 64'h1_0000_0000, -64'h8000_0000}, 0);
        send_word('{OP_UDIV, MaxVal, 64'(0)}, 0);
        send_word('{OP_SHL, AllOnes, 64'(63)}, 0);
        send_word('{OP_ASHR, MinVal, 64'(64)}, 0);
        send_word('{OP_LSHR, MinVal, AllOnes}, 0);
        send_word('{5'd23, MaxVal, MaxVal}, 0);
        send_word('{5'd31, AllOnes, AllOnes}, 0);
        for (int k = 0; k <= OP_UGE; k++)
        begin
            r.req_type = k[4:0];
            r.left_operand = ops[k % 10];
            r.right_operand = ops[(k * 3 + 1) % 10];
            send_word(r, k % 3);
        end
    endtask

    initial
    begin
        req_t r;
        int burst;
        board = new();
        in_valid = 1'b0;
        in_data = '0;
        sending_done = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        burst = 0;
        for (int n = 0; n < NumRandom; n++)
        begin
            if (burst > 0) burst--;
            else if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
            r.req_type = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(23, 31))
                : 5'($urandom_range(0, OP_UGE));
            r.left_operand = pick_operand();
            r.right_operand = pick_operand();
            if (r.req_type inside {OP_SHL, OP_LSHR, OP_ASHR} && $urandom_range(0, 3) != 0)
                r.right_operand = 64'($urandom_range(0, 63));
            send_word(r, pick_gap(burst));
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // receiver: long hold-off once early so the pipe fills and blocks input
    initial
    begin
        int gap;
        int burst;
        out_ready = 1'b0;
        burst = 0;
        wait (rst_n === 1'b1);
        repeat (300) @(posedge clk);
        forever
        begin
            if (burst > 0) burst--;
            else if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
            gap = pick_gap(burst);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_result(out_data);
        end
    end

    initial
    begin
        wait (sending_done === 1'b1);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (PipeDepth + 20) @(posedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/cia_pkg.sv
rtl/cia_div_cell.sv
rtl/cia_front.sv
rtl/checked_integer_alu_top.sv
tb/sv/tb_checked_integer_alu_top.sv
